[rtl/relative_orientation_quaternion_defines.svh]
// ----------------------------------------------------------------------------
// relative orientation quaternion assertion macros
// Shared concurrent assertion forms, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_ORIENTATION_QUATERNION_DEFINES_SVH
`define RELATIVE_ORIENTATION_QUATERNION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RLQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlq assertion failed");

// next-cycle implication
`define RLQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlq assertion failed");

`else

`define RLQ_ASSERT_IMP(label, ante, cons)
`define RLQ_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/rlq_pkg.sv]
// ----------------------------------------------------------------------------
// rlq_pkg
// Types, constants and product tables of the relative orientation block.
// ----------------------------------------------------------------------------
package rlq_pkg;

  localparam int CW   = 16;          // component width, Q1.(CW-1)
  localparam int FRAC = CW - 1;
  localparam int AW   = 2 * CW + 2;  // accumulator holds four full products
  localparam int CNTW = $clog2(CW + 1);

  // component indexes
  localparam logic [1:0] IX = 2'd0;
  localparam logic [1:0] IY = 2'd1;
  localparam logic [1:0] IZ = 2'd2;
  localparam logic [1:0] IW = 2'd3;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t quat_t [4];

  typedef struct packed {
    logic  kind;
    comp_t ref_x;
    comp_t ref_y;
    comp_t ref_z;
    comp_t ref_w;
    comp_t diff_x;
    comp_t diff_y;
    comp_t diff_z;
    comp_t diff_w;
  } in_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
  } out_t;

  // control from the sequencer to the serial multiply-accumulate
  typedef struct packed {
    logic load;   // take operands, start a term
    logic first;  // first term of a component: preset rounding half
    logic step;   // consume one multiplier bit
    logic neg;    // term enters with minus sign
    logic last;   // multiplier sign bit
  } mac_ctl_t;

  // a operand of term t of a Hamilton product
  function automatic logic [1:0] term_a(input logic [1:0] t);
    logic [1:0] r;
    case (t)
      2'd0:    r = IW;
      2'd1:    r = IX;
      2'd2:    r = IY;
      default: r = IZ;
    endcase
    return r;
  endfunction

  // b operand of term t for result component c
  function automatic logic [1:0] term_b(input logic [1:0] c, input logic [1:0] t);
    logic [1:0] r;
    r = IW;
    case (c)
      IX: case (t)
        2'd0: r = IX; 2'd1: r = IW; 2'd2: r = IZ; default: r = IY;
      endcase
      IY: case (t)
        2'd0: r = IY; 2'd1: r = IZ; 2'd2: r = IW; default: r = IX;
      endcase
      IZ: case (t)
        2'd0: r = IZ; 2'd1: r = IY; 2'd2: r = IX; default: r = IW;
      endcase
      default: case (t)
        2'd0: r = IW; 2'd1: r = IX; 2'd2: r = IY; default: r = IZ;
      endcase
    endcase
    return r;
  endfunction

  // sign of term t for result component c
  function automatic logic term_neg(input logic [1:0] c, input logic [1:0] t);
    logic r;
    case (c)
      IX:      r = (t == 2'd3);
      IY:      r = (t == 2'd1);
      IZ:      r = (t == 2'd2);
      default: r = (t != 2'd0);
    endcase
    return r;
  endfunction

  // drop fraction bits and saturate to a component
  function automatic comp_t sat_round(input logic signed [AW-1:0] acc);
    logic signed [AW-FRAC-1:0] v;
    comp_t r;
    v = acc[AW-1:FRAC];
    if (v[AW-FRAC-1:CW-1] == '0 || v[AW-FRAC-1:CW-1] == '1)
      r = v[CW-1:0];
    else
      r = v[AW-FRAC-1] ? C_MIN : C_MAX;
    return r;
  endfunction

  // saturating negate for the conjugate
  function automatic comp_t neg_sat(input comp_t x);
    comp_t r;
    r = (x == C_MIN) ? C_MAX : comp_t'(-x);
    return r;
  endfunction

endpackage

[rtl/relative_orientation_quaternion.sv]
// ----------------------------------------------------------------------------
// relative_orientation_quaternion
// Relative orientation offset * conj(Rr*ref) * (Rd*diff), Q1.15, serial.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid / in_stall / in_data carries kind, ref and diff
//   quaternions; a transfer happens when in_valid is high and in_stall low
// - kind 1 captures conj(ref) and conj(diff) as zero orientations and
//   gives no result; kind 0 computes one result
// - result channel out_valid / out_stall / out_data holds a result in an
//   output register until the receiver takes it
// - the four Hamilton products run on one bit-serial multiply-accumulate:
//   4 products x 4 components x 4 terms, each term one load plus one
//   step per multiplier bit; an update item then passes write-back and
//   output load before out_valid rises
// - the next item is taken once the result sits in the output register;
//   a stalled receiver holds the block in its done state only if the
//   previous result has not been taken yet
// - user writes offset cfg_idx (x,y,z,w) by cfg_we only when idle; unenforced
// - synchronous reset sets offset, Rr and Rd to identity and empties the
//   output register
// ----------------------------------------------------------------------------
`include "relative_orientation_quaternion_defines.svh"

module relative_orientation_quaternion (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlq_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_idx,
  input  rlq_pkg::comp_t cfg_data
);
  import rlq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(CW);

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r;
  logic [1:0]      t_r, c_r, q_r;
  logic            wb_v_r;
  logic [1:0]      wb_q_r, wb_c_r;
  logic            out_valid_r;
  out_t            out_r;

  comp_t off_r [4];
  comp_t rr_r  [4];
  comp_t rd_r  [4];
  comp_t refq_r[4];
  comp_t difq_r[4];
  comp_t ca_r  [4];   // conj(Rr*ref)
  comp_t bq_r  [4];   // Rd*diff
  comp_t cq_r  [4];
  comp_t dq_r  [4];

  mac_ctl_t ctl;
  comp_t    op_a, op_b, mac_res;
  logic     in_xfer, out_free, term_end;
  logic [1:0] ia, ib;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign term_end  = (state_r == ST_RUN) && (cnt_r == CNT_LAST);

  // operand select
  always_comb begin
    ia = term_a(t_r);
    ib = term_b(c_r, t_r);
    case (q_r)
      2'd0:    begin op_a = rr_r[ia];  op_b = refq_r[ib]; end
      2'd1:    begin op_a = rd_r[ia];  op_b = difq_r[ib]; end
      2'd2:    begin op_a = ca_r[ia];  op_b = bq_r[ib];   end
      default: begin op_a = off_r[ia]; op_b = cq_r[ib];   end
    endcase
  end

  // mac control
  always_comb begin
    ctl.load  = (state_r == ST_RUN) && (cnt_r == '0);
    ctl.step  = (state_r == ST_RUN) && (cnt_r != '0);
    ctl.first = (t_r == 2'd0);
    ctl.neg   = term_neg(c_r, t_r);
    ctl.last  = (cnt_r == CNT_LAST);
  end

  rlq_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .a   (op_a),
    .b   (op_b),
    .res (mac_res)
  );

  // state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer && !in_data.kind) state_nxt = ST_RUN;
      ST_RUN:   if (term_end && t_r == 2'd3 && c_r == 2'd3 && q_r == 2'd3)
                  state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      t_r         <= '0;
      c_r         <= '0;
      q_r         <= '0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wb_v_r  <= term_end && (t_r == 2'd3);
      if (in_xfer) begin
        cnt_r <= '0;
        t_r   <= '0;
        c_r   <= '0;
        q_r   <= '0;
      end else if (state_r == ST_RUN) begin
        if (term_end) begin
          cnt_r <= '0;
          t_r   <= t_r + 2'd1;
          if (t_r == 2'd3) begin
            c_r <= c_r + 2'd1;
            if (c_r == 2'd3) q_r <= q_r + 2'd1;
          end
        end else begin
          cnt_r <= cnt_r + CNTW'(1);
        end
      end
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
    end
  end

  // write-back target of the finished component
  always_ff @(posedge clk) begin
    if (term_end && t_r == 2'd3) begin
      wb_q_r <= q_r;
      wb_c_r <= c_r;
    end
  end

  // quaternion storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        off_r[i] <= '0;
        rr_r[i]  <= '0;
        rd_r[i]  <= '0;
      end
      off_r[IW] <= C_MAX;
      rr_r[IW]  <= C_MAX;
      rd_r[IW]  <= C_MAX;
    end else begin
      if (cfg_we) off_r[cfg_idx] <= cfg_data;
      if (in_xfer && in_data.kind) begin
        rr_r[IX] <= neg_sat(in_data.ref_x);
        rr_r[IY] <= neg_sat(in_data.ref_y);
        rr_r[IZ] <= neg_sat(in_data.ref_z);
        rr_r[IW] <= in_data.ref_w;
        rd_r[IX] <= neg_sat(in_data.diff_x);
        rd_r[IY] <= neg_sat(in_data.diff_y);
        rd_r[IZ] <= neg_sat(in_data.diff_z);
        rd_r[IW] <= in_data.diff_w;
      end
    end
  end

  // item operands and intermediate products
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      refq_r[IX] <= in_data.ref_x;
      refq_r[IY] <= in_data.ref_y;
      refq_r[IZ] <= in_data.ref_z;
      refq_r[IW] <= in_data.ref_w;
      difq_r[IX] <= in_data.diff_x;
      difq_r[IY] <= in_data.diff_y;
      difq_r[IZ] <= in_data.diff_z;
      difq_r[IW] <= in_data.diff_w;
    end
    if (wb_v_r) begin
      case (wb_q_r)
        2'd0:    ca_r[wb_c_r] <= (wb_c_r == IW) ? mac_res : neg_sat(mac_res);
        2'd1:    bq_r[wb_c_r] <= mac_res;
        2'd2:    cq_r[wb_c_r] <= mac_res;
        default: dq_r[wb_c_r] <= mac_res;
      endcase
    end
    if (state_r == ST_DONE && out_free) begin
      out_r.out_x <= dq_r[IX];
      out_r.out_y <= dq_r[IY];
      out_r.out_z <= dq_r[IZ];
      out_r.out_w <= dq_r[IW];
    end
  end

  // checks
  `RLQ_ASSERT_NXT(a_upd_starts, in_xfer && !in_data.kind, state_r == ST_RUN)
  `RLQ_ASSERT_NXT(a_cap_no_run, in_xfer && in_data.kind, state_r == ST_IDLE)
  `RLQ_ASSERT_NXT(a_out_load, state_r == ST_DONE && out_free, out_valid_r)
  `RLQ_ASSERT_IMP(a_cnt_range, state_r == ST_RUN, cnt_r <= CNT_LAST)

endmodule

[rtl/rlq_mac.sv]
// ----------------------------------------------------------------------------
// rlq_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rlq_mac (
  input  logic                  clk,
  input  rlq_pkg::mac_ctl_t     ctl,
  input  rlq_pkg::comp_t        a,
  input  rlq_pkg::comp_t        b,
  output rlq_pkg::comp_t        res
);
  import rlq_pkg::*;

  logic signed [AW-1:0] mc_r;
  logic        [CW-1:0] mp_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] addend;
  logic                 sub;

  // sign bit of the multiplier carries negative weight
  assign sub    = ctl.neg ^ ctl.last;
  assign addend = sub ? ~mc_r : mc_r;

  // shift and add
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mc_r <= {{(AW-CW){a[CW-1]}}, a};
      mp_r <= b;
      if (ctl.first) begin
        acc_r <= AW'(1) <<< (FRAC - 1);
      end
    end else if (ctl.step) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + addend + AW'(sub);
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign res = sat_round(acc_r);

endmodule

[tb/tb_relative_orientation_quaternion.sv]
// ----------------------------------------------------------------------------
// tb_relative_orientation_quaternion
// Drives update and capture transfers with random content and idling on both
// channels, predicts each orientation result in fixed point, compares fields.
// ----------------------------------------------------------------------------
module tb_relative_orientation_quaternion;
  import rlq_pkg::*;

  typedef enum logic {KIND_UPDATE = 1'b0, KIND_CAPTURE = 1'b1} kind_e;
  typedef enum logic [1:0] {REG_OFS_X = 2'd0, REG_OFS_Y = 2'd1, REG_OFS_Z = 2'd2,
                            REG_OFS_W = 2'd3} reg_e;
  typedef struct {
    longint x, y, z, w;
  } q_t;

  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_CYCLES = 1100;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  logic  cfg_we;
  logic [1:0] cfg_idx;
  comp_t cfg_data;

  relative_orientation_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor state
  q_t   offset_q, ref_zero, diff_zero;
  in_t  pending_items[$];
  out_t expected_orient[$];
  int   errors;
  int   idle_cycles;
  bit   sender_idle_on, receiver_idle_on;
  int   hold_off;
  bit   in_ok;

  function automatic longint clamp(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // exact sum, round half up, saturate
  function automatic longint fold(longint a, longint b, longint c, longint d);
    longint s;
    s = a + b + c + d + 16384;
    return clamp(s >>> 15);
  endfunction

  function automatic q_t hamilton(q_t a, q_t b);
    q_t r;
    r.w = fold(a.w * b.w, -(a.x * b.x), -(a.y * b.y), -(a.z * b.z));
    r.x = fold(a.w * b.x, a.x * b.w, a.y * b.z, -(a.z * b.y));
    r.y = fold(a.w * b.y, -(a.x * b.z), a.y * b.w, a.z * b.x);
    r.z = fold(a.w * b.z, a.x * b.y, -(a.y * b.x), a.z * b.w);
    return r;
  endfunction

  function automatic q_t conjugate(q_t a);
    q_t r;
    r.x = clamp(-a.x); r.y = clamp(-a.y); r.z = clamp(-a.z); r.w = a.w;
    return r;
  endfunction

  function automatic q_t mkq(comp_t x, comp_t y, comp_t z, comp_t w);
    q_t r;
    r.x = x; r.y = y; r.z = z; r.w = w;
    return r;
  endfunction

  // apply one accepted transfer to the predictor
  task automatic predict_orientation(in_t it);
    q_t rq, dq, a, b, d;
    out_t o;
    rq = mkq(it.ref_x, it.ref_y, it.ref_z, it.ref_w);
    dq = mkq(it.diff_x, it.diff_y, it.diff_z, it.diff_w);
    if (kind_e'(it.kind) == KIND_CAPTURE) begin
      ref_zero = conjugate(rq);
      diff_zero = conjugate(dq);
    end else begin
      a = hamilton(ref_zero, rq);
      b = hamilton(diff_zero, dq);
      d = hamilton(offset_q, hamilton(conjugate(a), b));
      o.out_x = comp_t'(d.x); o.out_y = comp_t'(d.y);
      o.out_z = comp_t'(d.z); o.out_w = comp_t'(d.w);
      expected_orient.push_back(o);
    end
  endtask

  function automatic comp_t rnd_comp();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2: return comp_t'(0);
      3: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // edge-heavy components in a quarter of items, else uniform in [-16384, 16383]
  function automatic in_t rnd_item(kind_e k);
    in_t it;
    it.kind = k;
    if ($urandom_range(0, 3) == 0) begin
      it.ref_x = rnd_comp(); it.ref_y = rnd_comp(); it.ref_z = rnd_comp();
      it.ref_w = rnd_comp(); it.diff_x = rnd_comp(); it.diff_y = rnd_comp();
      it.diff_z = rnd_comp(); it.diff_w = rnd_comp();
    end else begin
      it.ref_x = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.ref_y = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.ref_z = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.ref_w = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.diff_x = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.diff_y = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.diff_z = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      it.diff_w = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
    end
    return it;
  endfunction

  function automatic in_t flat_item(kind_e k, comp_t r, comp_t d);
    in_t it;
    it.kind = k;
    it.ref_x = r; it.ref_y = r; it.ref_z = r; it.ref_w = r;
    it.diff_x = d; it.diff_y = d; it.diff_z = d; it.diff_w = d;
    return it;
  endfunction

  // register write while the block is idle
  task automatic write_offset(reg_e idx, comp_t val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFS_X: offset_q.x = val;
      REG_OFS_Y: offset_q.y = val;
      REG_OFS_Z: offset_q.z = val;
      default:   offset_q.w = val;
    endcase
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && expected_orient.size() == 0);
    repeat (ITEM_CYCLES + 20) @(negedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver: next item offered at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ok) begin
        if (pending_items.size() > 0 && !(sender_idle_on && $urandom_range(0, 99) < 36))
        begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall plus counted hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off <= hold_off - 1;
      end else begin
        out_stall <= receiver_idle_on && ($urandom_range(0, 99) < 36);
      end
    end
  end

  // monitor at the rising edge
  always @(posedge clk) begin
    in_ok = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_ok = 1'b1;
        predict_orientation(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_orient.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.out_x !== expected_orient[0].out_x)
            $display("%0t: out_x expected %0d actual %0d", $time,
                     expected_orient[0].out_x, out_data.out_x);
          if (out_data.out_y !== expected_orient[0].out_y)
            $display("%0t: out_y expected %0d actual %0d", $time,
                     expected_orient[0].out_y, out_data.out_y);
          if (out_data.out_z !== expected_orient[0].out_z)
            $display("%0t: out_z expected %0d actual %0d", $time,
                     expected_orient[0].out_z, out_data.out_z);
          if (out_data.out_w !== expected_orient[0].out_w)
            $display("%0t: out_w expected %0d actual %0d", $time,
                     expected_orient[0].out_w, out_data.out_w);
          if (out_data !== expected_orient[0]) errors++;
          void'(expected_orient.pop_front());
        end
      end
      idle_cycles <= (in_ok || (out_valid && !out_stall)) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    comp_t edge_vals[4];
    errors = 0; idle_cycles = 0; hold_off = 0; in_ok = 1'b0;
    sender_idle_on = 1'b0; receiver_idle_on = 1'b0;
    in_valid = 1'b0; out_stall = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_idx = REG_OFS_X; cfg_data = '0;
    offset_q = mkq(0, 0, 0, C_MAX);
    ref_zero = offset_q; diff_zero = offset_q;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset state, extremes, most negative conjugate, captures
    edge_vals = '{C_MAX, C_MIN, comp_t'(0), comp_t'(-1)};
    pending_items.push_back(flat_item(KIND_UPDATE, comp_t'(0), comp_t'(0)));
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 2)
        pending_items.push_back(flat_item(KIND_UPDATE, edge_vals[i], edge_vals[j]));
    pending_items.push_back(flat_item(KIND_CAPTURE, C_MIN, C_MIN));
    pending_items.push_back(flat_item(KIND_UPDATE, C_MIN, C_MAX));
    pending_items.push_back(flat_item(KIND_CAPTURE, C_MAX, comp_t'(-1)));
    pending_items.push_back(flat_item(KIND_UPDATE, C_MAX, C_MIN));
    pending_items.push_back(flat_item(KIND_CAPTURE, comp_t'(0), comp_t'(0)));
    pending_items.push_back(flat_item(KIND_UPDATE, C_MIN, C_MIN));
    drain();

    // offset extremes, then random settings per phase, identity in the last
    write_offset(REG_OFS_X, C_MIN); write_offset(REG_OFS_Y, C_MAX);
    write_offset(REG_OFS_Z, C_MIN); write_offset(REG_OFS_W, C_MIN);
    pending_items.push_back(flat_item(KIND_UPDATE, C_MIN, C_MAX));
    pending_items.push_back(flat_item(KIND_UPDATE, C_MAX, C_MAX));
    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 6; i++) pending_items.push_back(rnd_item(KIND_UPDATE));
    hold_off = 3000;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      sender_idle_on = (ph != 2);
      receiver_idle_on = (ph != 2);
      if (ph == 5) begin
        write_offset(REG_OFS_X, comp_t'(0)); write_offset(REG_OFS_Y, comp_t'(0));
        write_offset(REG_OFS_Z, comp_t'(0)); write_offset(REG_OFS_W, C_MAX);
      end else begin
        write_offset(REG_OFS_X, rnd_comp()); write_offset(REG_OFS_Y, rnd_comp());
        write_offset(REG_OFS_Z, rnd_comp()); write_offset(REG_OFS_W, rnd_comp());
      end
      for (int i = 0; i < 300; i++)
        pending_items.push_back(rnd_item($urandom_range(0, 4) == 0 ? KIND_CAPTURE
                                                                   : KIND_UPDATE));
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
